### design/hfvd_pkg.sv
package hfvd_pkg;

	localparam int POS_W = 16;
	localparam int QUEUE_DEPTH = 2;

	// Byte positions, lengths and the shoot slot inside a frame.
	localparam logic [POS_W-1:0] POS_HEADER_FIRST = 16'd0;
	localparam logic [POS_W-1:0] POS_HEADER_SECOND = 16'd1;
	localparam logic [POS_W-1:0] POS_KIND = 16'd4;
	localparam logic [POS_W-1:0] POS_CSUM_HIGH = 16'd7;
	localparam logic [POS_W-1:0] POS_FIELD_FIRST = 16'd8;
	localparam logic [POS_W-1:0] POS_FIELD_LAST = 16'd14;
	localparam logic [POS_W-1:0] POS_SHOOT = 16'd17;
	localparam logic [POS_W-1:0] SHORT_MAX_LEN = 16'd8;
	localparam logic [POS_W-1:0] CSUM_PAD_LEN = 16'd7;
	localparam logic [2:0] SLOT_SHOOT = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] REG_HEADER_FIRST = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_ARMOR_KIND = 2'd2;
	localparam logic [1:0] REG_BUFF_KIND = 2'd3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
	localparam logic [1:0] STATUS_BAD_HEADER = 2'd2;
	localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_ARMOR = 2'd1;
	localparam logic [1:0] KIND_BUFF = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         packet_kind;
		logic [7:0]         target_found;
		logic [31:0]        yaw_bits;
		logic signed [15:0] pitch_value;
		logic [7:0]         shoot_flag;
		logic [15:0]        sum_computed;
	} out_item_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] armor_kind_code;
		logic [7:0] buff_kind_code;
	} cfg_t;

	// One classified byte as handed from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       take;
		logic       odd;
		logic       csum_high;
		logic       hdr_first;
		logic       hdr_second;
		logic       kind;
		logic       capture;
		logic [2:0] slot;
		logic       pad;
		logic       too_short;
	} fe_entry_t;

endpackage

### design/host_frame_verify_decode_top.sv
// Frame checker and decoder: takes one received byte per transfer on the input
// channel and, at the byte flagged last, gives one result with the frame status
// (ok, too short, bad header, checksum mismatch), the packet kind and, for a
// buff packet, its decoded fields; every result also carries the computed word
// sum. A byte is taken every cycle while the queue has room; the front end
// counts positions, a two-entry queue decouples it from the back end that
// accumulates the sum and captures fields, and the result register holds the
// outcome. The user must write header and kind codes through the config port
// only while no frame is in flight; the block itself does not enforce this.
// Frames longer than MAX_FRAME_BYTES keep counting only up to that limit.
module host_frame_verify_decode_top
	import hfvd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t      cfg_q;
	logic      push_valid;
	logic      push_ready;
	fe_entry_t push_entry;
	logic      pop_valid;
	logic      pop;
	fe_entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_FIRST:  cfg_q.header_first <= cfg_data;
				REG_HEADER_SECOND: cfg_q.header_second <= cfg_data;
				REG_ARMOR_KIND:    cfg_q.armor_kind_code <= cfg_data;
				REG_BUFF_KIND:     cfg_q.buff_kind_code <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	hfvd_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	hfvd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_entry(pop_entry)
	);

	hfvd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_entry(pop_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

### design/hfvd_front.sv
module hfvd_front
	import hfvd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      push_valid,
	input  logic      push_ready,
	output fe_entry_t push_entry
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] len;
	logic             take;
	logic             accept;

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;

	assign take = count_q < CNT_W'(MAX_FRAME_BYTES);
	assign pos = POS_W'(count_q);
	assign len = take ? POS_W'(pos + 16'd1) : pos;

	always_comb begin
		push_entry = '0;
		push_entry.data = in_data.data_byte;
		push_entry.last = in_data.last_byte;
		push_entry.take = take;
		push_entry.odd = pos[0];
		push_entry.csum_high = pos == POS_CSUM_HIGH;
		push_entry.hdr_first = pos == POS_HEADER_FIRST;
		push_entry.hdr_second = pos == POS_HEADER_SECOND;
		push_entry.kind = pos == POS_KIND;
		push_entry.capture = (pos >= POS_FIELD_FIRST && pos <= POS_FIELD_LAST) ||
			pos == POS_SHOOT;
		push_entry.slot = (pos == POS_SHOOT) ? SLOT_SHOOT : 3'(pos - POS_FIELD_FIRST);
		// An odd-length frame folds its lone last byte into the sum, unless that
		// byte would be the low half of the checksum word.
		push_entry.pad = len[0] && len != CSUM_PAD_LEN;
		push_entry.too_short = len <= SHORT_MAX_LEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				count_q <= '0;
			end else if (take) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_BYTES))
		else $error("byte counter ran past its saturation value");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=> count_q == '0)
		else $error("byte counter not cleared after the last byte of a frame");
`endif

endmodule

### design/hfvd_queue.sv
module hfvd_queue
	import hfvd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  fe_entry_t push_entry,
	output logic      pop_valid,
	input  logic      pop,
	output fe_entry_t pop_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fe_entry_t        slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];
	assign push = push_valid && push_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy above its depth");
`endif

endmodule

### design/hfvd_back.sv
module hfvd_back
	import hfvd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pop_valid,
	output logic      pop,
	input  fe_entry_t pop_entry,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [15:0] running_q;
	logic [7:0]  hold_q;
	logic        hdr_ok_q;
	logic [15:0] recv_q;
	logic [7:0]  kind_q;
	logic [63:0] cap_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [15:0] word;
	logic [15:0] addend;
	logic [15:0] running_n;
	logic [7:0]  hold_n;
	logic        hdr_ok_n;
	logic [15:0] recv_n;
	logic [7:0]  kind_n;
	logic [63:0] cap_n;
	logic        took;
	out_item_t   result;

	// A frame's last byte waits only while the result register is still full.
	assign pop = pop_valid && (!pop_entry.last || !out_valid_q || out_ready);
	assign took = pop_entry.take;
	assign word = {pop_entry.data, hold_q};

	always_comb begin
		hold_n = (took && !pop_entry.odd) ? pop_entry.data : hold_q;
		hdr_ok_n = hdr_ok_q;
		if (took && pop_entry.hdr_first && pop_entry.data != cfg.header_first) begin
			hdr_ok_n = 1'b0;
		end
		if (took && pop_entry.hdr_second && pop_entry.data != cfg.header_second) begin
			hdr_ok_n = 1'b0;
		end
		kind_n = (took && pop_entry.kind) ? pop_entry.data : kind_q;
		recv_n = (took && pop_entry.csum_high) ? word : recv_q;
		cap_n = cap_q;
		if (took && pop_entry.capture) begin
			cap_n[{pop_entry.slot, 3'b000} +: 8] = pop_entry.data;
		end
		// A word add and the odd-length pad never fall on the same byte.
		if (took && pop_entry.odd && !pop_entry.csum_high) begin
			addend = word;
		end else if (pop_entry.last && pop_entry.pad) begin
			addend = {8'h00, hold_n};
		end else begin
			addend = '0;
		end
		running_n = running_q + addend;
	end

	always_comb begin
		result = '0;
		result.sum_computed = running_n;
		priority if (pop_entry.too_short) begin
			result.status = STATUS_TOO_SHORT;
		end else if (!hdr_ok_n) begin
			result.status = STATUS_BAD_HEADER;
		end else if (running_n != recv_n) begin
			result.status = STATUS_BAD_SUM;
		end else begin
			result.status = STATUS_OK;
		end
		if (result.status == STATUS_OK) begin
			priority if (kind_n == cfg.armor_kind_code) begin
				result.packet_kind = KIND_ARMOR;
			end else if (kind_n == cfg.buff_kind_code) begin
				result.packet_kind = KIND_BUFF;
			end else begin
				result.packet_kind = KIND_OTHER;
			end
		end
		if (result.packet_kind == KIND_BUFF) begin
			result.target_found = cap_n[7:0];
			result.yaw_bits = cap_n[39:8];
			result.pitch_value = cap_n[55:40];
			result.shoot_flag = cap_n[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			hold_q <= '0;
			hdr_ok_q <= 1'b1;
			recv_q <= '0;
			kind_q <= '0;
			cap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_entry.last) begin
					running_q <= '0;
					hold_q <= '0;
					hdr_ok_q <= 1'b1;
					recv_q <= '0;
					kind_q <= '0;
					cap_q <= '0;
					out_valid_q <= 1'b1;
				end else begin
					running_q <= running_n;
					hold_q <= hold_n;
					hdr_ok_q <= hdr_ok_n;
					recv_q <= recv_n;
					kind_q <= kind_n;
					cap_q <= cap_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && pop_entry.last))
		else $error("result raised without a frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.packet_kind == KIND_OTHER || out_q.status == STATUS_OK))
		else $error("packet kind given for a frame that failed its checks");
`endif

endmodule

### tb/sv/hfvd_tb_pkg.sv
package hfvd_tb_pkg;
	import hfvd_pkg::*;

	localparam int FRAME_LIMIT = 65535;

	// Tracks the frame in flight as the bytes are accepted, works out the verdict
	// at the last byte and holds verdicts until the block hands them out.
	class frame_verdicts;
		cfg_t regs;
		int unsigned byte_count;
		logic [15:0] running_sum;
		logic [15:0] sum_received;
		logic [7:0] low_hold;
		logic [7:0] kind_byte;
		bit header_ok;
		logic [63:0] fields;
		out_item_t expected_verdicts[$];
		int err_count;
		int status_seen[4];
		int armor_seen;
		int buff_seen;

		function new();
			regs = '0;
			err_count = 0;
			armor_seen = 0;
			buff_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_count = 0;
			running_sum = '0;
			sum_received = '0;
			low_hold = '0;
			kind_byte = '0;
			header_ok = 1'b1;
			fields = '0;
		endfunction

		function void note_byte(in_item_t item);
			int unsigned pos;
			logic [7:0] b;
			out_item_t v;
			b = item.data_byte;
			// Past the length limit a byte is dropped, but its last mark still counts.
			if (byte_count < FRAME_LIMIT) begin
				pos = byte_count;
				if (pos == 0 && b != regs.header_first) header_ok = 1'b0;
				if (pos == 1 && b != regs.header_second) header_ok = 1'b0;
				if (pos == 4) kind_byte = b;
				if (pos >= 8 && pos <= 14) fields[(pos - 8) * 8 +: 8] = b;
				if (pos == 17) fields[63:56] = b;
				if (pos % 2 == 0) begin
					low_hold = b;
				end else if (pos == 7) begin
					sum_received = {b, low_hold};
				end else begin
					running_sum += {b, low_hold};
				end
				byte_count++;
			end
			if (!item.last_byte) return;

			// An odd last byte forms a word with a zero high byte, unless that word
			// lands on the checksum offset.
			if (byte_count % 2 == 1 && byte_count != 7) running_sum += {8'h00, low_hold};

			v = '0;
			if (byte_count <= 8) v.status = STATUS_TOO_SHORT;
			else if (!header_ok) v.status = STATUS_BAD_HEADER;
			else if (running_sum != sum_received) v.status = STATUS_BAD_SUM;
			else v.status = STATUS_OK;

			v.packet_kind = KIND_OTHER;
			if (v.status == STATUS_OK) begin
				if (kind_byte == regs.armor_kind_code) v.packet_kind = KIND_ARMOR;
				else if (kind_byte == regs.buff_kind_code) v.packet_kind = KIND_BUFF;
			end
			if (v.packet_kind == KIND_BUFF) begin
				v.target_found = fields[7:0];
				v.yaw_bits = fields[39:8];
				v.pitch_value = fields[55:40];
				v.shoot_flag = fields[63:56];
				buff_seen++;
			end
			if (v.packet_kind == KIND_ARMOR) armor_seen++;
			v.sum_computed = running_sum;
			status_seen[v.status]++;
			expected_verdicts.push_back(v);
			clear_frame();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				err_count++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result transfer with no frame outstanding: %h", got);
				err_count++;
				return;
			end
			want = expected_verdicts.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("packet_kind", want.packet_kind, got.packet_kind);
			compare_field("target_found", want.target_found, got.target_found);
			compare_field("yaw_bits", want.yaw_bits, got.yaw_bits);
			compare_field("pitch_value", want.pitch_value, got.pitch_value);
			compare_field("shoot_flag", want.shoot_flag, got.shoot_flag);
			compare_field("sum_computed", want.sum_computed, got.sum_computed);
		endfunction
	endclass

endpackage

### tb/sv/testbench.sv
module testbench;
	import hfvd_pkg::*;
	import hfvd_tb_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 250;

	typedef enum {FK_ARMOR, FK_BUFF, FK_OTHER} frame_kind_e;
	typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_HEADER_FIRST;
	logic [7:0] cfg_data = '0;

	frame_verdicts verdicts;
	logic [7:0] frame_q[$];
	int burst_left = 0;
	int bytes_accepted = 0;
	int idle_cycles = 0;
	int settings_used = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	rx_mode_e rx_mode = RX_FREE;
	int mode_left = 0;

	always #4 clk = ~clk;

	host_frame_verify_decode_top #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			verdicts.note_byte(in_data);
			bytes_accepted++;
		end
		if (out_valid && out_ready) verdicts.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL host_frame_verify_decode_top");
			$finish;
		end
	end

	// Result side: switches between stall patterns, and once holds off for a
	// long stretch so that the block backs up into its input.
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (mode_left % 3 == 0);
			endcase
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: l};
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts.expected_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic write_regs(input cfg_t c);
		write_reg(REG_HEADER_FIRST, c.header_first);
		write_reg(REG_HEADER_SECOND, c.header_second);
		write_reg(REG_ARMOR_KIND, c.armor_kind_code);
		write_reg(REG_BUFF_KIND, c.buff_kind_code);
		@(negedge clk);
		cfg_we <= 1'b0;
		verdicts.regs = c;
		settings_used++;
	endtask

	// Builds a frame against the current register settings. A negative fill
	// gives random payload bytes.
	function automatic void build_frame(int len, bit hdr_good, frame_kind_e kind,
			bit sum_good, int fill = -1);
		logic [15:0] sum;
		logic [7:0] pick;
		int idx;
		frame_q.delete();
		for (int i = 0; i < len; i++)
			frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
		if (len > 0) frame_q[0] = verdicts.regs.header_first;
		if (len > 1) frame_q[1] = verdicts.regs.header_second;
		if (!hdr_good && len > 0) begin
			idx = (len > 1) ? $urandom_range(0, 1) : 0;
			frame_q[idx] ^= 8'(1 << $urandom_range(0, 7));
		end
		if (len > 4) begin
			case (kind)
				FK_ARMOR: frame_q[4] = verdicts.regs.armor_kind_code;
				FK_BUFF: frame_q[4] = verdicts.regs.buff_kind_code;
				default: begin
					do begin
						pick = 8'($urandom_range(0, 255));
					end while (pick == verdicts.regs.armor_kind_code ||
						pick == verdicts.regs.buff_kind_code);
					frame_q[4] = pick;
				end
			endcase
		end
		if (len >= 8) begin
			sum = '0;
			for (int i = 0; i < len; i += 2)
				if (i != 6) sum += {(i + 1 < len) ? frame_q[i + 1] : 8'h00, frame_q[i]};
			if (!sum_good) sum += 16'($urandom_range(1, 65535));
			frame_q[6] = sum[7:0];
			frame_q[7] = sum[15:8];
		end
	endfunction

	task automatic random_frame();
		int r;
		int len;
		frame_kind_e kind;
		r = $urandom_range(0, 99);
		kind = frame_kind_e'($urandom_range(0, 2));
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(9, 24);
		if (r < 70) begin
			build_frame(len, 1'b1, kind, 1'b1);
		end else if (r < 80) begin
			build_frame($urandom_range(1, 8), 1'($urandom_range(0, 1)), kind,
				1'($urandom_range(0, 1)));
		end else if (r < 90) begin
			build_frame(len, 1'b0, kind, 1'($urandom_range(0, 1)));
		end else begin
			build_frame(len, 1'b1, kind, 1'b0);
		end
		send_frame();
	endtask

	initial begin
		cfg_t c;
		int sent;
		verdicts = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Registers still at reset: an all-zero frame is a valid armor packet.
		build_frame(9, 1'b1, FK_ARMOR, 1'b1, 0);
		send_frame();
		build_frame(18, 1'b1, FK_BUFF, 1'b1);
		send_frame();
		drain_results();

		write_regs('{header_first: 8'hA5, header_second: 8'h5A,
			armor_kind_code: 8'h01, buff_kind_code: 8'h02});
		build_frame(1, 1'b1, FK_OTHER, 1'b1);
		send_frame();
		// Seven bytes: the padded last word falls on the checksum offset.
		build_frame(7, 1'b1, FK_BUFF, 1'b1);
		send_frame();
		build_frame(8, 1'b1, FK_ARMOR, 1'b1);
		send_frame();
		build_frame(9, 1'b1, FK_ARMOR, 1'b1);
		send_frame();
		build_frame(9, 1'b0, FK_ARMOR, 1'b1);
		send_frame();
		build_frame(18, 1'b1, FK_BUFF, 1'b1);
		send_frame();
		// Buff packet that stops before the pitch and shoot bytes.
		build_frame(13, 1'b1, FK_BUFF, 1'b1);
		send_frame();
		build_frame(20, 1'b1, FK_BUFF, 1'b0);
		send_frame();
		build_frame(11, 1'b1, FK_OTHER, 1'b1);
		send_frame();
		drain_results();

		// Both kind codes equal: the frame must come out as armor.
		write_regs('1);
		build_frame(18, 1'b1, FK_BUFF, 1'b1, 8'hFF);
		send_frame();
		drain_results();

		for (int p = 0; p < 6; p++) begin
			c = '{header_first: 8'($urandom_range(0, 255)),
				header_second: 8'($urandom_range(0, 255)),
				armor_kind_code: 8'($urandom_range(0, 255)),
				buff_kind_code: 8'($urandom_range(0, 255))};
			if (p == 2) c = '0;
			if (p == 4) c = '{header_first: 8'hFF, header_second: 8'hFF,
				armor_kind_code: 8'h00, buff_kind_code: 8'hFF};
			write_regs(c);
			sent = 0;
			if (p == 2) begin
				random_frame();
				sent += frame_q.size();
				hold_request = 1'b1;
			end
			while (sent < PHASE_BYTES) begin
				random_frame();
				sent += frame_q.size();
			end
			drain_results();
		end

		if (verdicts.expected_verdicts.size() != 0) begin
			$error("%0d frame verdicts never came out", verdicts.expected_verdicts.size());
			verdicts.err_count++;
		end
		$display("Checked %0d ok frames (%0d armor, %0d buff), %0d too short, %0d bad header,",
			verdicts.status_seen[STATUS_OK], verdicts.armor_seen, verdicts.buff_seen,
			verdicts.status_seen[STATUS_TOO_SHORT], verdicts.status_seen[STATUS_BAD_HEADER]);
		$display("%0d bad checksum; %0d bytes in over %0d register settings.",
			verdicts.status_seen[STATUS_BAD_SUM], bytes_accepted, settings_used);
		if (verdicts.err_count == 0) begin
			$display("PASS host_frame_verify_decode_top");
		end else begin
			$display("FAIL host_frame_verify_decode_top");
		end
		$finish;
	end

endmodule
